[design/pal_pkg.sv]
package pal_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] CAP_RESET = 6'd32;

  localparam logic [1:0] KIND_APPEND  = 2'd0;
  localparam logic [1:0] KIND_INSERT  = 2'd1;
  localparam logic [1:0] KIND_DELETE  = 2'd2;
  localparam logic [1:0] KIND_REVERSE = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_POS   = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_APPEND,
    ST_INS_CHK,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_DEL_RD0,
    ST_DEL_CAP,
    ST_DEL_CHK,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_REV_CHK,
    ST_REV_RDLO,
    ST_REV_RDHI,
    ST_REV_WRLO,
    ST_REV_WRHI,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    ADDR_LO,
    ADDR_HI,
    ADDR_HI_M1,
    ADDR_LO_P1,
    ADDR_COUNT,
    ADDR_POS
  } addr_sel_e;

  typedef enum logic [1:0] {
    WDATA_VALUE,
    WDATA_RDATA,
    WDATA_TMP
  } wdata_sel_e;

  typedef enum logic [1:0] {
    LO_KEEP,
    LO_ZERO,
    LO_POS,
    LO_INC
  } lo_op_e;

  typedef enum logic [1:0] {
    HI_KEEP,
    HI_COUNT,
    HI_COUNT_M1,
    HI_DEC
  } hi_op_e;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic       item_load;
    logic       rd_en;
    addr_sel_e  rd_sel;
    logic       wr_en;
    addr_sel_e  wr_sel;
    wdata_sel_e wdata_sel;
    lo_op_e     lo_op;
    hi_op_e     hi_op;
    cnt_op_e    cnt_op;
    logic       tmp_load;
    logic       removed_load;
    logic       stat_load;
    logic [1:0] stat_code;
    logic       out_load;
  } pal_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       empty;
    logic       pos_ok;
    logic       ins_more;
    logic       del_more;
    logic       rev_more;
    logic       rev_any;
    logic       out_free;
  } pal_stat_t;

endpackage

[design/pal_ctrl.sv]
module pal_ctrl
  import pal_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pal_stat_t stat_i,
  output pal_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat_i.kind)
          KIND_APPEND:  state_d = stat_i.full ? ST_DONE : ST_APPEND;
          KIND_INSERT:  state_d = (stat_i.full || !stat_i.pos_ok) ? ST_DONE : ST_INS_CHK;
          KIND_DELETE:  state_d = (stat_i.empty || !stat_i.pos_ok) ? ST_DONE : ST_DEL_RD0;
          default:      state_d = stat_i.rev_any ? ST_REV_CHK : ST_DONE;
        endcase
      end
      ST_APPEND:   state_d = ST_DONE;
      ST_INS_CHK:  state_d = stat_i.ins_more ? ST_INS_RD : ST_INS_PUT;
      ST_INS_RD:   state_d = ST_INS_WR;
      ST_INS_WR:   state_d = ST_INS_CHK;
      ST_INS_PUT:  state_d = ST_DONE;
      ST_DEL_RD0:  state_d = ST_DEL_CAP;
      ST_DEL_CAP:  state_d = ST_DEL_CHK;
      ST_DEL_CHK:  state_d = stat_i.del_more ? ST_DEL_RD : ST_DONE;
      ST_DEL_RD:   state_d = ST_DEL_WR;
      ST_DEL_WR:   state_d = ST_DEL_CHK;
      ST_REV_CHK:  state_d = stat_i.rev_more ? ST_REV_RDLO : ST_DONE;
      ST_REV_RDLO: state_d = ST_REV_RDHI;
      ST_REV_RDHI: state_d = ST_REV_WRLO;
      ST_REV_WRLO: state_d = ST_REV_WRHI;
      ST_REV_WRHI: state_d = ST_REV_CHK;
      ST_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o         = 1'b0;
    cmd_o.item_load    = 1'b0;
    cmd_o.rd_en        = 1'b0;
    cmd_o.rd_sel       = ADDR_LO;
    cmd_o.wr_en        = 1'b0;
    cmd_o.wr_sel       = ADDR_LO;
    cmd_o.wdata_sel    = WDATA_VALUE;
    cmd_o.lo_op        = LO_KEEP;
    cmd_o.hi_op        = HI_KEEP;
    cmd_o.cnt_op       = CNT_KEEP;
    cmd_o.tmp_load     = 1'b0;
    cmd_o.removed_load = 1'b0;
    cmd_o.stat_load    = 1'b0;
    cmd_o.stat_code    = STAT_OK;
    cmd_o.out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.item_load = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.stat_load = 1'b1;
        unique case (stat_i.kind)
          KIND_APPEND: begin
            if (stat_i.full) cmd_o.stat_code = STAT_FULL;
          end
          KIND_INSERT: begin
            if (stat_i.full) begin
              cmd_o.stat_code = STAT_FULL;
            end else if (!stat_i.pos_ok) begin
              cmd_o.stat_code = STAT_POS;
            end
            cmd_o.hi_op = HI_COUNT;
          end
          KIND_DELETE: begin
            if (stat_i.empty) begin
              cmd_o.stat_code = STAT_EMPTY;
            end else if (!stat_i.pos_ok) begin
              cmd_o.stat_code = STAT_POS;
            end
            cmd_o.lo_op = LO_POS;
          end
          default: begin
            cmd_o.lo_op = LO_ZERO;
            cmd_o.hi_op = HI_COUNT_M1;
          end
        endcase
      end
      ST_APPEND: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = ADDR_COUNT;
        cmd_o.wdata_sel = WDATA_VALUE;
        cmd_o.cnt_op    = CNT_INC;
      end
      ST_INS_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ADDR_HI_M1;
      end
      ST_INS_WR: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = ADDR_HI;
        cmd_o.wdata_sel = WDATA_RDATA;
        cmd_o.hi_op     = HI_DEC;
      end
      ST_INS_PUT: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = ADDR_POS;
        cmd_o.wdata_sel = WDATA_VALUE;
        cmd_o.cnt_op    = CNT_INC;
      end
      ST_DEL_RD0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ADDR_POS;
      end
      ST_DEL_CAP: begin
        cmd_o.removed_load = 1'b1;
      end
      ST_DEL_CHK: begin
        if (!stat_i.del_more) cmd_o.cnt_op = CNT_DEC;
      end
      ST_DEL_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ADDR_LO_P1;
      end
      ST_DEL_WR: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = ADDR_LO;
        cmd_o.wdata_sel = WDATA_RDATA;
        cmd_o.lo_op     = LO_INC;
      end
      ST_REV_RDLO: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ADDR_LO;
      end
      ST_REV_RDHI: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = ADDR_HI;
        cmd_o.tmp_load = 1'b1;
      end
      ST_REV_WRLO: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = ADDR_LO;
        cmd_o.wdata_sel = WDATA_RDATA;
      end
      ST_REV_WRHI: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = ADDR_HI;
        cmd_o.wdata_sel = WDATA_TMP;
        cmd_o.lo_op     = LO_INC;
        cmd_o.hi_op     = HI_DEC;
      end
      ST_DONE: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[design/pal_dpath.sv]
module pal_dpath
  import pal_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic [1:0]       kind_i,
  input  logic [4:0]       position_i,
  input  logic [31:0]      value_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [1:0]       status_o,
  output logic [31:0]      removed_value_o,
  output logic [CNT_W-1:0] count_o,
  input  pal_cmd_t         cmd_i,
  output pal_stat_t        stat_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (AW > CNT_W) ? AW : CNT_W;

  logic [31:0]      mem [DEPTH];
  logic [31:0]      rdata_q;
  logic [31:0]      tmp_q;
  logic [31:0]      removed_q;
  logic [1:0]       kind_q;
  logic [4:0]       pos_q;
  logic [31:0]      value_q;
  logic [1:0]       stat_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] capacity_q;
  logic [PW-1:0]    lo_q, lo_d;
  logic [PW-1:0]    hi_q, hi_d;
  logic             out_valid_q;
  logic [1:0]       out_stat_q;
  logic [31:0]      out_removed_q;
  logic [CNT_W-1:0] out_count_q;

  logic [PW-1:0]    lo_p1;
  logic [PW-1:0]    hi_m1;
  logic [PW-1:0]    count_w;
  logic [PW-1:0]    pos_w;
  logic [PW-1:0]    rd_addr_w;
  logic [PW-1:0]    wr_addr_w;
  logic [31:0]      wdata;

  assign lo_p1   = lo_q + PW'(1);
  assign hi_m1   = hi_q - PW'(1);
  assign count_w = PW'(count_q);
  assign pos_w   = PW'(pos_q);

  function automatic logic [PW-1:0] addr_mux(input addr_sel_e sel, input logic [PW-1:0] lo,
                                             input logic [PW-1:0] hi, input logic [PW-1:0] hm1,
                                             input logic [PW-1:0] lp1, input logic [PW-1:0] cnt,
                                             input logic [PW-1:0] pos);
    logic [PW-1:0] a;
    case (sel)
      ADDR_LO:    a = lo;
      ADDR_HI:    a = hi;
      ADDR_HI_M1: a = hm1;
      ADDR_LO_P1: a = lp1;
      ADDR_COUNT: a = cnt;
      ADDR_POS:   a = pos;
      default:    a = lo;
    endcase
    return a;
  endfunction

  assign rd_addr_w = addr_mux(cmd_i.rd_sel, lo_q, hi_q, hi_m1, lo_p1, count_w, pos_w);
  assign wr_addr_w = addr_mux(cmd_i.wr_sel, lo_q, hi_q, hi_m1, lo_p1, count_w, pos_w);

  always_comb begin
    case (cmd_i.wdata_sel)
      WDATA_VALUE: wdata = value_q;
      WDATA_RDATA: wdata = rdata_q;
      WDATA_TMP:   wdata = tmp_q;
      default:     wdata = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_w[AW-1:0]] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr_w[AW-1:0]];
    end
  end

  always_comb begin
    lo_d = lo_q;
    case (cmd_i.lo_op)
      LO_ZERO: lo_d = '0;
      LO_POS:  lo_d = pos_w;
      LO_INC:  lo_d = lo_p1;
      default: lo_d = lo_q;
    endcase
    hi_d = hi_q;
    case (cmd_i.hi_op)
      HI_COUNT:    hi_d = count_w;
      HI_COUNT_M1: hi_d = count_w - PW'(1);
      HI_DEC:      hi_d = hi_m1;
      default:     hi_d = hi_q;
    endcase
    count_d = count_q;
    case (cmd_i.cnt_op)
      CNT_INC: count_d = count_q + CNT_W'(1);
      CNT_DEC: count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.item_load) begin
      kind_q  <= kind_i;
      pos_q   <= position_i;
      value_q <= value_i;
    end
    if (cmd_i.tmp_load) begin
      tmp_q <= rdata_q;
    end
    if (cmd_i.item_load) begin
      removed_q <= '0;
    end else if (cmd_i.removed_load) begin
      removed_q <= rdata_q;
    end
    if (cmd_i.stat_load) begin
      stat_q <= cmd_i.stat_code;
    end
    if (cmd_i.out_load) begin
      out_stat_q    <= stat_q;
      out_removed_q <= removed_q;
      out_count_q   <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      capacity_q  <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.kind     = kind_q;
  assign stat_o.full     = (count_q >= capacity_q) || (32'(count_q) >= DEPTH);
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.pos_ok   = ({1'b0, pos_q} < count_q);
  assign stat_o.ins_more = (hi_q > pos_w);
  assign stat_o.del_more = (lo_p1 < count_w);
  assign stat_o.rev_more = (lo_q < hi_q);
  assign stat_o.rev_any  = (count_q > CNT_W'(1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_stat_q;
  assign removed_value_o = out_removed_q;
  assign count_o         = out_count_q;

endmodule

[design/positional_array_list.sv]
// Ordered list of signed 32-bit values held in one single-port-per-direction memory of DEPTH
// entries, of which the first min(capacity, DEPTH) are usable. Each input item is an append,
// insert, delete or reverse and yields exactly one result item with status, removed value and
// new count. One item is worked on at a time. An insert or delete shifts the list tail
// at the position, and a reverse swaps pairs from both ends; every moved entry passes through
// the memory's registered read port and then its write port. The next item can be taken in
// the cycle after the result is loaded. A finished result waits in the output register
// while the next item is taken, and the block stalls before loading a new result while
// that register is still held. The capacity register may be written only while idle.
module positional_array_list
  import pal_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [39:0]      s_axis_tdata,  // position[4:0], value[36:5], zero pad
  input  logic [1:0]       s_axis_tuser,  // kind[1:0]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // removed_value[31:0], count[37:32], zero pad
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  pal_cmd_t         cmd;
  pal_stat_t        stat;
  logic [31:0]      removed_value;
  logic [CNT_W-1:0] count;

  pal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pal_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .kind_i          (s_axis_tuser),
    .position_i      (s_axis_tdata[4:0]),
    .value_i         (s_axis_tdata[36:5]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .status_o        (m_axis_tuser),
    .removed_value_o (removed_value),
    .count_o         (count),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

  assign m_axis_tdata = {2'b00, count, removed_value};

endmodule
